// ===== hw/rtl/dfpf_pkg.sv =====
package dfpf_pkg;

  // Fixed field widths of the stream and configuration payloads.
  localparam int PIX_BITS      = 16;
  localparam int ROW_BITS      = 11;
  localparam int FW_BITS       = 10;
  localparam int RAD_BITS      = 2;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  // Reset values of the configuration registers.
  localparam int RADIUS_RST    = 1;
  localparam int THRESHOLD_RST = 20;
  localparam int WIDTH_RST     = 512;
  localparam int HEIGHT_RST    = 424;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RADIUS    = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_WIDTH     = 2'd2,
    REG_HEIGHT    = 2'd3
  } cfg_reg_t;

endpackage

// ===== hw/rtl/dfpf_ram.sv =====
module dfpf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/depth_flying_pixel_filter_unit.sv =====
// Flying-pixel filter for a streamed depth image.
// Input stream (s_*): one item per depth sample in raster order. s_tdata holds
// the 16-bit sample, s_tuser the flush flag; a flush item carries no sample and
// only lets the delayed tail of a finished frame drain out.
// Output stream (m_*): filtered samples in raster order, zero where a pixel is
// judged flying; m_tuser flags such a pixel, m_tlast marks the bottom right
// pixel of a frame. A sample leaves R rows plus R items after it entered.
// Config channel (cfg_*): radius, depth threshold, frame width and height,
// written while the stream is idle; cfg_ready is always high.
// Throughput: one item per cycle while the output is not stalled. An item that
// releases a result passes three registers: the line-buffer/FIFO read stage,
// the compare stage and the output register, which drives m_tvalid.
// Line buffers (2*MAX_RADIUS rows in one RAM word per column) feed the window;
// a centre FIFO of MAX_RADIUS*MAX_WIDTH+MAX_RADIUS+1 samples gives the output
// value of every pixel, border pixels included.
// Reset clears positions, counts and pipeline valids and restores the register
// defaults; RAM contents are not cleared. When m_tready is low, the result
// holds and items keep flowing in until the pipeline stages behind it fill.
module depth_flying_pixel_filter_unit #(
  parameter int MAX_RADIUS = 2,
  parameter int MAX_WIDTH  = 512
) (
  input  logic                                clk,
  input  logic                                rst,
  // input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [dfpf_pkg::PIX_BITS-1:0]       s_tdata,   // [15:0] pixel_in
  input  logic                                s_tuser,   // [0] flush
  // output stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [dfpf_pkg::PIX_BITS-1:0]       m_tdata,   // [15:0] pixel_out
  output logic                                m_tuser,   // [0] removed
  output logic                                m_tlast,   // frame_last
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dfpf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [dfpf_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int PIX  = dfpf_pkg::PIX_BITS;
  localparam int RWB  = dfpf_pkg::ROW_BITS;
  localparam int RB   = $clog2(MAX_RADIUS + 1);
  localparam int WB   = $clog2(MAX_WIDTH + 1);
  localparam int CB   = $clog2(MAX_WIDTH);
  localparam int SIDE = 2 * MAX_RADIUS + 1;
  localparam int NCELL = SIDE * SIDE;
  localparam int CNTB = $clog2(NCELL + 1);
  localparam int LROWS = 2 * MAX_RADIUS;
  localparam int FIFO_DEPTH = MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1;
  localparam int FB   = $clog2(FIFO_DEPTH);
  localparam int PB   = $clog2(FIFO_DEPTH + 1);
  localparam int TB   = $clog2(MAX_WIDTH * 2047 + 1);
  localparam int W_RST = (dfpf_pkg::WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH
                                                           : dfpf_pkg::WIDTH_RST;
  localparam int R_RST = (dfpf_pkg::RADIUS_RST > MAX_RADIUS) ? MAX_RADIUS
                                                             : dfpf_pkg::RADIUS_RST;

  // ---------------------------------------------------------------------------
  // Configuration: keep the effective (clamped) values and the derived delay
  // and frame size in registers, so an item right after a write sees them.
  // ---------------------------------------------------------------------------
  logic [RB-1:0]  r_eff, r_next;
  logic [PIX-1:0] thr, thr_next;
  logic [WB-1:0]  w_eff, w_next;
  logic [RWB-1:0] h_eff, h_next;
  logic [PB-1:0]  delay, delay_next;
  logic [TB-1:0]  total, total_next;

  logic [dfpf_pkg::RAD_BITS-1:0] r_raw;
  logic [dfpf_pkg::FW_BITS-1:0]  w_raw;
  logic [RWB-1:0]                h_raw;

  assign cfg_ready = 1'b1;
  assign r_raw = cfg_data[dfpf_pkg::RAD_BITS-1:0];
  assign w_raw = cfg_data[dfpf_pkg::FW_BITS-1:0];
  assign h_raw = cfg_data[RWB-1:0];

  always_comb begin
    r_next   = r_eff;
    thr_next = thr;
    w_next   = w_eff;
    h_next   = h_eff;
    if (cfg_valid) begin
      unique case (dfpf_pkg::cfg_reg_t'(cfg_index))
        dfpf_pkg::REG_RADIUS: begin
          // zero acts as one, anything above the maximum as the maximum
          if (r_raw == '0) begin
            r_next = RB'(1);
          end else if (32'(r_raw) > MAX_RADIUS) begin
            r_next = RB'(MAX_RADIUS);
          end else begin
            r_next = RB'(r_raw);
          end
        end
        dfpf_pkg::REG_THRESHOLD: begin
          thr_next = cfg_data;
        end
        dfpf_pkg::REG_WIDTH: begin
          if (w_raw == '0) begin
            w_next = WB'(1);
          end else if (32'(w_raw) > MAX_WIDTH) begin
            w_next = WB'(MAX_WIDTH);
          end else begin
            w_next = WB'(w_raw);
          end
        end
        dfpf_pkg::REG_HEIGHT: begin
          h_next = (h_raw == '0) ? RWB'(1) : h_raw;
        end
        default: begin
        end
      endcase
    end
    delay_next = PB'(PB'(r_next) * PB'(w_next) + PB'(r_next));
    total_next = TB'(TB'(w_next) * TB'(h_next));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_eff <= RB'(R_RST);
      thr   <= PIX'(dfpf_pkg::THRESHOLD_RST);
      w_eff <= WB'(W_RST);
      h_eff <= RWB'(dfpf_pkg::HEIGHT_RST);
      delay <= PB'(R_RST * W_RST + R_RST);
      total <= TB'(W_RST * dfpf_pkg::HEIGHT_RST);
    end else begin
      r_eff <= r_next;
      thr   <= thr_next;
      w_eff <= w_next;
      h_eff <= h_next;
      delay <= delay_next;
      total <= total_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake: each stage advances when the one after it is free.
  // ---------------------------------------------------------------------------
  logic s1_valid, s1_pix, s1_emit, s1_interior, s1_last, s1_bypass;
  logic [PIX-1:0] s1_data;
  logic [CB-1:0]  s1_col;
  logic s2_valid, s2_last;
  logic [PIX-1:0] s2_centre;
  logic [NCELL-1:0] s2_bad;

  logic out_free, s2_free, s1_go, acc, is_pix;

  assign out_free = !m_tvalid || m_tready;
  assign s2_free  = !s2_valid || out_free;
  assign s1_go    = s1_valid && (!s1_emit || s2_free);
  assign s_tready = !s1_valid || s1_go;
  assign acc      = s_tvalid && s_tready;
  assign is_pix   = !s_tuser;

  // ---------------------------------------------------------------------------
  // Stage 0: raster positions, pending count and the emit decision.
  // ---------------------------------------------------------------------------
  logic [CB-1:0]  in_col, out_col;
  logic [RWB-1:0] in_row, out_row;
  logic [TB-1:0]  out_lin;
  logic [PB-1:0]  pending, pending_new;
  logic [FB-1:0]  wr_ptr, rd_ptr;

  logic frame_done, emit, interior;
  logic in_col_wrap, in_row_wrap, out_col_wrap, out_row_wrap;

  assign pending_new = pending + PB'(is_pix);
  // the whole frame of the next output pixel has been received
  assign frame_done = (TB + 1)'(out_lin) + (TB + 1)'(pending_new) >= (TB + 1)'(total);
  assign emit = (pending_new != '0) && ((pending_new > delay) || frame_done);

  assign interior = (RWB'(r_eff) <= out_row)
                 && ((RWB + 1)'(out_row) + (RWB + 1)'(r_eff) < (RWB + 1)'(h_eff))
                 && ((WB + 1)'(r_eff) <= (WB + 1)'(out_col))
                 && ((WB + 1)'(out_col) + (WB + 1)'(r_eff) < (WB + 1)'(w_eff));

  assign in_col_wrap  = (WB + 1)'(in_col) + (WB + 1)'(1) >= (WB + 1)'(w_eff);
  assign in_row_wrap  = (RWB + 1)'(in_row) + (RWB + 1)'(1) >= (RWB + 1)'(h_eff);
  assign out_col_wrap = (WB + 1)'(out_col) + (WB + 1)'(1) >= (WB + 1)'(w_eff);
  assign out_row_wrap = (RWB + 1)'(out_row) + (RWB + 1)'(1) >= (RWB + 1)'(h_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      out_lin <= '0;
      pending <= '0;
      wr_ptr  <= '0;
      rd_ptr  <= '0;
    end else if (acc) begin
      pending <= pending_new - PB'(emit);
      if (is_pix) begin
        wr_ptr <= (wr_ptr == FB'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + FB'(1);
        if (in_col_wrap) begin
          in_col <= '0;
          in_row <= in_row_wrap ? '0 : in_row + RWB'(1);
        end else begin
          in_col <= in_col + CB'(1);
        end
      end
      if (emit) begin
        rd_ptr <= (rd_ptr == FB'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + FB'(1);
        if (out_col_wrap) begin
          out_col <= '0;
          out_row <= out_row_wrap ? '0 : out_row + RWB'(1);
          out_lin <= out_row_wrap ? '0 : out_lin + TB'(1);
        end else begin
          out_col <= out_col + CB'(1);
          out_lin <= out_lin + TB'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix      <= is_pix;
      s1_data     <= s_tdata;
      s1_col      <= in_col;
      s1_emit     <= emit;
      s1_interior <= interior;
      s1_last     <= out_col_wrap && out_row_wrap;
      // FIFO empty before this sample: its head is the sample itself
      s1_bypass   <= is_pix && (pending == '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Memories: centre FIFO and line buffers (all 2*MAX_RADIUS rows per word).
  // ---------------------------------------------------------------------------
  logic [PIX-1:0]         fifo_rdata;
  logic [LROWS*PIX-1:0]   lb_rdata, lb_wdata;
  logic                   lb_we;

  dfpf_ram #(
    .WIDTH (PIX),
    .DEPTH (FIFO_DEPTH)
  ) u_centre_fifo (
    .clk   (clk),
    .we    (acc && is_pix),
    .waddr (wr_ptr),
    .wdata (s_tdata),
    .re    (acc),
    .raddr (rd_ptr),
    .rdata (fifo_rdata)
  );

  dfpf_ram #(
    .WIDTH (LROWS * PIX),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (lb_we),
    .waddr (s1_col),
    .wdata (lb_wdata),
    .re    (acc),
    .raddr (in_col),
    .rdata (lb_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: window column, window shift and neighbor compares.
  // Window cell [a][b] holds the sample a rows and b items before the newest.
  // ---------------------------------------------------------------------------
  logic [PIX-1:0] col   [SIDE];
  logic [PIX-1:0] win   [SIDE][SIDE-1];
  logic [PIX-1:0] nview [SIDE][SIDE];
  logic [PIX-1:0] centre;
  logic [PIX:0]   diff;
  logic [NCELL-1:0] bad;

  assign lb_we  = s1_go && s1_pix;
  assign centre = s1_bypass ? s1_data : fifo_rdata;

  always_comb begin
    col[0] = s1_data;
    for (int a = 1; a < SIDE; a++) begin
      col[a] = lb_rdata[(a - 1) * PIX +: PIX];
    end
    for (int j = 0; j < LROWS; j++) begin
      lb_wdata[j * PIX +: PIX] = col[j];
    end
    for (int a = 0; a < SIDE; a++) begin
      nview[a][0] = col[a];
      for (int b = 1; b < SIDE; b++) begin
        nview[a][b] = win[a][b - 1];
      end
    end
  end

  always_comb begin
    diff = '0;
    bad  = '0;
    for (int a = 0; a < SIDE; a++) begin
      for (int b = 0; b < SIDE; b++) begin
        diff = (nview[a][b] > centre) ? ({1'b0, nview[a][b]} - {1'b0, centre})
                                      : ({1'b0, centre} - {1'b0, nview[a][b]});
        // count only cells inside the active window, centre excluded
        bad[a * SIDE + b] = s1_interior
                         && (a <= 2 * int'(r_eff)) && (b <= 2 * int'(r_eff))
                         && !((a == int'(r_eff)) && (b == int'(r_eff)))
                         && (diff > {1'b0, thr});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lb_we) begin
      for (int a = 0; a < SIDE; a++) begin
        win[a][0] <= col[a];
        for (int b = 1; b < SIDE - 1; b++) begin
          win[a][b] <= win[a][b - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_go && s1_emit) begin
      s2_valid <= 1'b1;
    end else if (out_free) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit) begin
      s2_bad    <= bad;
      s2_centre <= centre;
      s2_last   <= s1_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: count misfits, drop the pixel above half the neighbors.
  // ---------------------------------------------------------------------------
  logic [CNTB-1:0] bad_cnt, limit;
  logic            cleared;

  always_comb begin
    bad_cnt = '0;
    for (int i = 0; i < NCELL; i++) begin
      bad_cnt = bad_cnt + CNTB'(s2_bad[i]);
    end
    limit   = CNTB'(CNTB'(r_eff) * (CNTB'(r_eff) + CNTB'(1)) * CNTB'(2));
    cleared = bad_cnt > limit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s2_valid && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && out_free) begin
      m_tdata <= cleared ? '0 : s2_centre;
      m_tuser <= cleared;
      m_tlast <= s2_last;
    end
  end

endmodule

// ===== bench/dfpf_pixel_checker.sv =====
module dfpf_pixel_checker #(
  parameter int MAX_RADIUS = 2,
  parameter int MAX_WIDTH  = 512
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  input  logic [dfpf_pkg::PIX_BITS-1:0]       s_tdata,   // [15:0] pixel_in
  input  logic                                s_tuser,   // [0] flush
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic [dfpf_pkg::PIX_BITS-1:0]       m_tdata,   // [15:0] pixel_out
  input  logic                                m_tuser,   // [0] removed
  input  logic                                m_tlast,   // frame_last
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [dfpf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [dfpf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output int unsigned                         fail_count,
  output int unsigned                         results_seen,
  output int unsigned                         awaiting
);

  localparam int PIX_BITS      = dfpf_pkg::PIX_BITS;
  localparam int RAD_BITS      = dfpf_pkg::RAD_BITS;
  localparam int FW_BITS       = dfpf_pkg::FW_BITS;
  localparam int ROW_BITS      = dfpf_pkg::ROW_BITS;
  localparam int CFG_DATA_BITS = dfpf_pkg::CFG_DATA_BITS;

  // sample history: twice the output delay plus slack, so no live entry is overwritten
  localparam int HIST_DEPTH = 2 * (MAX_RADIUS * MAX_WIDTH + MAX_RADIUS) + 2;

  typedef struct {
    logic [PIX_BITS-1:0] depth;
    logic                removed;
    logic                frame_last;
  } pixel_result_t;

  typedef struct {
    int unsigned col;
    int unsigned row;
    bit          wrapped;
  } raster_t;

  pixel_result_t           filtered_q[$];
  logic [PIX_BITS-1:0]     depth_hist[HIST_DEPTH];
  int unsigned             wr_ptr;
  int unsigned             backlog;
  int unsigned             in_col;
  int unsigned             in_row;
  int unsigned             out_col;
  int unsigned             out_row;
  logic [RAD_BITS-1:0]     radius;
  logic [CFG_DATA_BITS-1:0] threshold;
  logic [FW_BITS-1:0]      frame_w;
  logic [ROW_BITS-1:0]     frame_h;
  int unsigned             n_fail = 0;
  int unsigned             n_seen = 0;

  function automatic int unsigned active_radius();
    if (radius < 1) return 1;
    if (radius > MAX_RADIUS) return MAX_RADIUS;
    return radius;
  endfunction

  function automatic int unsigned active_width();
    if (frame_w < 1) return 1;
    if (frame_w > MAX_WIDTH) return MAX_WIDTH;
    return frame_w;
  endfunction

  function automatic int unsigned active_height();
    return (frame_h < 1) ? 1 : frame_h;
  endfunction

  // step a raster position; flag the wrap into a new frame
  function automatic raster_t next_pos(int unsigned col, int unsigned row,
                                       int unsigned w, int unsigned h);
    raster_t p;
    p.col     = col + 1;
    p.row     = row;
    p.wrapped = 1'b0;
    if (col + 1 >= w) begin
      p.col = 0;
      if (row + 1 >= h) begin
        p.row     = 0;
        p.wrapped = 1'b1;
      end else begin
        p.row = row + 1;
      end
    end
    return p;
  endfunction

  function automatic logic [PIX_BITS-1:0] hist_at(int offset);
    int p;
    p = (int'(wr_ptr) + offset) % HIST_DEPTH;
    if (p < 0) p += HIST_DEPTH;
    return depth_hist[p];
  endfunction

  task automatic clear_state();
    radius    = RAD_BITS'(dfpf_pkg::RADIUS_RST);
    threshold = CFG_DATA_BITS'(dfpf_pkg::THRESHOLD_RST);
    frame_w   = FW_BITS'(dfpf_pkg::WIDTH_RST);
    frame_h   = ROW_BITS'(dfpf_pkg::HEIGHT_RST);
    for (int i = 0; i < HIST_DEPTH; i++) depth_hist[i] = '0;
    wr_ptr  = 0;
    backlog = 0;
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
    filtered_q.delete();
  endtask

  task automatic load_register(dfpf_pkg::cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] value);
    case (idx)
      dfpf_pkg::REG_RADIUS:    radius    = value[RAD_BITS-1:0];
      dfpf_pkg::REG_THRESHOLD: threshold = value;
      dfpf_pkg::REG_WIDTH:     frame_w   = value[FW_BITS-1:0];
      dfpf_pkg::REG_HEIGHT:    frame_h   = value[ROW_BITS-1:0];
      default: ;
    endcase
  endtask

  // take one input item and queue the filtered pixel it releases, if any
  task automatic judge_pixel(logic [PIX_BITS-1:0] sample, logic is_flush);
    int unsigned         r;
    int unsigned         w;
    int unsigned         h;
    int unsigned         delay;
    int unsigned         total;
    int unsigned         out_idx;
    int unsigned         n_bad;
    int unsigned         diff;
    logic [PIX_BITS-1:0] centre;
    logic [PIX_BITS-1:0] v;
    logic                interior;
    logic                cleared;
    raster_t             p;
    pixel_result_t       res;
    r     = active_radius();
    w     = active_width();
    h     = active_height();
    delay = r * w + r;
    total = w * h;
    if (!is_flush) begin
      depth_hist[wr_ptr] = sample;
      wr_ptr  = (wr_ptr + 1) % HIST_DEPTH;
      backlog = backlog + 1;
      p       = next_pos(in_col, in_row, w, h);
      in_col  = p.col;
      in_row  = p.row;
    end
    out_idx = out_row * w + out_col;
    if (backlog == 0 || (backlog <= delay && out_idx + backlog < total)) return;

    centre   = hist_at(-int'(backlog));
    interior = out_row >= r && out_row + r < h && out_col >= r && out_col + r < w;
    n_bad    = 0;
    cleared  = 1'b0;
    if (interior) begin
      for (int dy = -int'(r); dy <= int'(r); dy++) begin
        for (int dx = -int'(r); dx <= int'(r); dx++) begin
          if (dy != 0 || dx != 0) begin
            v    = hist_at(-int'(backlog) + dy * int'(w) + dx);
            diff = (v > centre) ? v - centre : centre - v;
            if (diff > threshold) n_bad++;
          end
        end
      end
      cleared = n_bad > 2 * r * (r + 1);
    end
    p       = next_pos(out_col, out_row, w, h);
    out_col = p.col;
    out_row = p.row;
    backlog = backlog - 1;

    res.depth      = cleared ? '0 : centre;
    res.removed    = cleared;
    res.frame_last = p.wrapped;
    filtered_q = {filtered_q, res};
  endtask

  task automatic note_failure();
    n_fail++;
  endtask

  task automatic compare_output();
    pixel_result_t want;
    n_seen++;
    if (filtered_q.size() == 0) begin
      $error("unexpected output item: pixel_out=%0d removed=%0b frame_last=%0b",
             m_tdata, m_tuser, m_tlast);
      note_failure();
      return;
    end
    want = filtered_q.pop_front();
    if (m_tdata !== want.depth) begin
      $error("pixel_out mismatch: expected %0d, actual %0d", want.depth, m_tdata);
      note_failure();
    end
    if (m_tuser !== want.removed) begin
      $error("removed mismatch: expected %0b, actual %0b", want.removed, m_tuser);
      note_failure();
    end
    if (m_tlast !== want.frame_last) begin
      $error("frame_last mismatch: expected %0b, actual %0b", want.frame_last, m_tlast);
      note_failure();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
    end else begin
      // older results first: nothing accepted at this edge can already be on the output
      if (m_tvalid && m_tready) compare_output();
      if (cfg_valid && cfg_ready) begin
        load_register(dfpf_pkg::cfg_reg_t'(cfg_index), cfg_data);
      end
      if (s_tvalid && s_tready) judge_pixel(s_tdata, s_tuser);
    end
    fail_count   <= n_fail;
    results_seen <= n_seen;
    awaiting     <= filtered_q.size();
  end

endmodule

// ===== bench/depth_flying_pixel_filter_unit_test.sv =====
module depth_flying_pixel_filter_unit_test;

  localparam int MAX_RADIUS    = 2;
  localparam int MAX_WIDTH     = 512;
  localparam int PIX_BITS      = dfpf_pkg::PIX_BITS;
  localparam int CFG_IDX_BITS  = dfpf_pkg::CFG_IDX_BITS;
  localparam int CFG_DATA_BITS = dfpf_pkg::CFG_DATA_BITS;

  logic                     clk;
  logic                     rst;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [PIX_BITS-1:0]      s_tdata;    // [15:0] pixel_in
  logic                     s_tuser;    // [0] flush
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [PIX_BITS-1:0]      m_tdata;    // [15:0] pixel_out
  logic                     m_tuser;    // [0] removed
  logic                     m_tlast;    // frame_last
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  int unsigned fail_count;
  int unsigned results_seen;
  int unsigned awaiting;
  int unsigned pixels_sent = 0;
  // no idling on either side while set
  logic        calm = 1'b0;

  depth_flying_pixel_filter_unit #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_WIDTH  (MAX_WIDTH)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dfpf_pixel_checker #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_WIDTH  (MAX_WIDTH)
  ) i_pixel_check (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .results_seen (results_seen),
    .awaiting     (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest correct run of a few hundred items.
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // Stall the output side about 30 percent of the time, never while calm.
  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 30);
  end

  // Hold the input channel idle for one cycle; scramble the payload meanwhile.
  task automatic hold_input();
    s_tvalid <= 1'b0;
    s_tdata  <= PIX_BITS'($urandom);
    s_tuser  <= 1'($urandom);
    @(posedge clk);
  endtask

  // Offer one item and wait for its handshake. Idle at random first.
  task automatic feed_depth(logic [PIX_BITS-1:0] sample, logic flush);
    while (!calm && $urandom_range(99) < 30) hold_input();
    s_tvalid <= 1'b1;
    s_tdata  <= sample;
    s_tuser  <= flush;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (!flush) pixels_sent++;
  endtask

  task automatic write_reg(dfpf_pkg::cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_index <= CFG_IDX_BITS'($urandom);
    cfg_data  <= CFG_DATA_BITS'($urandom);
    @(posedge clk);
  endtask

  // Pause the sender until every predicted pixel has come out.
  task automatic wait_for_results();
    do hold_input(); while (awaiting != 0);
  endtask

  // At a frame boundary: push flushes until every pixel has been returned,
  // then let the pipeline go quiet before any register write.
  task automatic drain_frame_tail();
    while (results_seen < pixels_sent) feed_depth(PIX_BITS'($urandom), 1'b1);
    do hold_input(); while (awaiting != 0 || results_seen < pixels_sent);
    repeat (8) hold_input();
  endtask

  // Mostly a flat surface with small jitter, plus spikes and the range ends.
  function automatic logic [PIX_BITS-1:0] depth_sample(logic [PIX_BITS-1:0] base);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) return base + PIX_BITS'($urandom_range(0, 24));
    if (pick < 80) return PIX_BITS'($urandom);
    if (pick < 90) return '0;
    return '1;
  endfunction

  // Write all four registers in random order, stream whole frames, drain.
  task automatic run_phase(int unsigned r, int unsigned thr, int unsigned w,
                           int unsigned h, int unsigned frames, bit noisy);
    dfpf_pkg::cfg_reg_t  order[4];
    dfpf_pkg::cfg_reg_t  tmp;
    int unsigned         j;
    int unsigned         w_eff;
    int unsigned         h_eff;
    logic [PIX_BITS-1:0] base;
    order[0] = dfpf_pkg::REG_RADIUS;
    order[1] = dfpf_pkg::REG_THRESHOLD;
    order[2] = dfpf_pkg::REG_WIDTH;
    order[3] = dfpf_pkg::REG_HEIGHT;
    for (int i = 0; i < 3; i++) begin
      j        = $urandom_range(i, 3);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    foreach (order[i]) begin
      case (order[i])
        dfpf_pkg::REG_RADIUS:    write_reg(dfpf_pkg::REG_RADIUS, CFG_DATA_BITS'(r));
        dfpf_pkg::REG_THRESHOLD: write_reg(dfpf_pkg::REG_THRESHOLD, CFG_DATA_BITS'(thr));
        dfpf_pkg::REG_WIDTH:     write_reg(dfpf_pkg::REG_WIDTH, CFG_DATA_BITS'(w));
        default:                 write_reg(dfpf_pkg::REG_HEIGHT, CFG_DATA_BITS'(h));
      endcase
    end
    // out-of-range width and height act as the nearest legal size
    w_eff = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
    h_eff = (h == 0) ? 1 : h;
    for (int f = 0; f < frames; f++) begin
      base = PIX_BITS'($urandom);
      for (int i = 0; i < w_eff * h_eff; i++) begin
        // a flush inside a frame just advances nothing
        if (noisy && $urandom_range(99) < 4) feed_depth(PIX_BITS'($urandom), 1'b1);
        if (noisy && $urandom_range(99) < 3) wait_for_results();
        feed_depth(depth_sample(base), 1'b0);
      end
    end
    drain_frame_tail();
  endtask

  // 5x5 frame, radius 1, threshold 20: lone spikes at both range ends, a
  // pixel exactly at the threshold from its flat neighbours, one just past
  // it, extreme values on the border, and a flush in mid frame.
  task automatic directed_frame();
    logic [PIX_BITS-1:0] pattern[25];
    foreach (pattern[i]) pattern[i] = 16'd1000;
    pattern[0]  = 16'hFFFF;   // border corner, passes through
    pattern[6]  = 16'd0;      // interior, far from every neighbour
    pattern[8]  = 16'd1021;   // one past the threshold from its flat neighbours
    pattern[12] = 16'hFFFF;   // centre spike
    pattern[18] = 16'd1020;   // exactly at the threshold, fits
    pattern[24] = 16'd0;      // last pixel of the frame, border
    write_reg(dfpf_pkg::REG_RADIUS, CFG_DATA_BITS'(1));
    write_reg(dfpf_pkg::REG_THRESHOLD, CFG_DATA_BITS'(20));
    write_reg(dfpf_pkg::REG_WIDTH, CFG_DATA_BITS'(5));
    write_reg(dfpf_pkg::REG_HEIGHT, CFG_DATA_BITS'(5));
    foreach (pattern[i]) begin
      if (i == 13) feed_depth(16'h5A5A, 1'b1);
      feed_depth(pattern[i], 1'b0);
    end
    drain_frame_tail();
  endtask

  initial begin
    int unsigned goal;
    int unsigned thr;
    int unsigned w;

    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= dfpf_pkg::REG_RADIUS;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    directed_frame();

    // Register extremes. One frame runs with no idling on either side.
    run_phase(2, 20, 5, 5, 1, 1'b0);
    calm <= 1'b1;
    run_phase(3, 0, 20, 5, 1, 1'b0);
    calm <= 1'b0;
    run_phase(0, 16'hFFFF, 0, 60, 1, 1'b0);
    run_phase(1, 100, 40, 0, 1, 1'b1);

    // Random small frames up to about 400 pixels in all, noise flushes mixed in.
    goal = 400;
    while (pixels_sent < goal) begin
      case ($urandom_range(3))
        0:       thr = 0;
        1:       thr = 16'hFFFF;
        2:       thr = $urandom_range(0, 40);
        default: thr = $urandom_range(0, 16'hFFFF);
      endcase
      w = ($urandom_range(9) == 0) ? $urandom_range(13, 16) : $urandom_range(5, 12);
      run_phase($urandom_range(0, 3), thr, w, $urandom_range(5, 8),
                $urandom_range(1, 2), 1'b1);
    end

    if (awaiting != 0) $error("%0d expected output items never arrived", awaiting);
    if (fail_count == 0 && awaiting == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
